/* rtl/plh_pkg.sv */
`default_nettype none
package plh_pkg;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [31:0]        handle;
		logic signed [31:0] priority_req;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [31:0]        out_handle;
		logic signed [31:0] out_priority;
		logic               last;
	} out_item_t;

	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_DUMP   = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [2:0] ST_ENTRY = 3'd0;
	localparam logic [2:0] ST_DONE  = 3'd1;
	localparam logic [2:0] ST_FULL  = 3'd2;
	localparam logic [2:0] ST_NULL  = 3'd3;
	localparam logic [2:0] ST_EMPTY = 3'd4;

	// command kinds handed from front to back
	localparam logic [2:0] K_ADD    = 3'd0;
	localparam logic [2:0] K_REMOVE = 3'd1;
	localparam logic [2:0] K_DUMP   = 3'd2;
	localparam logic [2:0] K_NULL   = 3'd3;
	localparam logic [2:0] K_DONE   = 3'd4;

	typedef struct packed {
		logic [2:0]         kind;
		logic [31:0]        handle;
		logic signed [31:0] prio;
	} cmd_t;

	// ascending by signed priority, ties by unsigned handle
	function automatic logic sorts_before(logic signed [31:0] pa, logic [31:0] ha,
			logic signed [31:0] pb, logic [31:0] hb);
		return (pa < pb) || ((pa == pb) && (ha < hb));
	endfunction

endpackage
`default_nettype wire

/* rtl/plh_front.sv */
`default_nettype none
module plh_front (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  plh_pkg::in_item_t in_data,
	output logic              q_valid,
	output plh_pkg::cmd_t     q_cmd,
	input  wire               q_pop
);
	import plh_pkg::*;

	localparam int unsigned QD = 2;

	cmd_t       q_mem_q [QD];
	logic       wr_q, rd_q;
	logic [1:0] fill_q;
	cmd_t       cls;
	logic       push;
	logic       pop;

	always_comb begin
		cls.handle = in_data.handle;
		cls.prio   = in_data.priority_req;
		case (in_data.opcode)
			OP_ADD:    cls.kind = (in_data.handle == 32'd0) ? K_NULL : K_ADD;
			OP_REMOVE: cls.kind = (in_data.handle == 32'd0) ? K_DONE : K_REMOVE;
			OP_DUMP:   cls.kind = K_DUMP;
			default:   cls.kind = K_DONE;
		endcase
	end

	assign in_ready = (fill_q != 2'(QD));
	// unused opcode is consumed without a queue entry
	assign push     = in_valid && in_ready && (in_data.opcode != OP_UNUSED);
	assign q_valid  = (fill_q != 2'd0);
	assign q_cmd    = q_mem_q[rd_q];
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= 1'b0;
			rd_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule
`default_nettype wire

/* rtl/plh_back.sv */
`default_nettype none
module plh_back #(
	parameter int unsigned CAPACITY = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                q_valid,
	input  plh_pkg::cmd_t      q_cmd,
	output logic               q_pop,
	output logic               out_valid,
	input  wire                out_ready,
	output plh_pkg::out_item_t out_data
);
	import plh_pkg::*;

	localparam int unsigned CW = $clog2(CAPACITY + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MATCH  = 3'd1;
	localparam logic [2:0] S_DROP   = 3'd2;
	localparam logic [2:0] S_INSERT = 3'd3;
	localparam logic [2:0] S_RESP   = 3'd4;
	localparam logic [2:0] S_DUMP   = 3'd5;

	logic [2:0]         state_q, state_d;
	logic [CW-1:0]      cnt_q, cnt_d;
	logic [CW-1:0]      idx_q, idx_d;
	logic [2:0]         resp_q, resp_d;
	cmd_t               cmd_q;
	logic               found_q;
	logic signed [31:0] mprio_q;

	logic [31:0]        cell_h_q [CAPACITY];
	logic signed [31:0] cell_p_q [CAPACITY];
	logic [31:0]        cell_h_d [CAPACITY];
	logic signed [31:0] cell_p_d [CAPACITY];
	logic               before_v [CAPACITY];

	logic               found_c;
	logic signed [31:0] mprio_c;

	logic               out_valid_q;
	out_item_t          out_data_q;
	logic               out_free;
	logic               emit;
	out_item_t          emit_data;
	logic               is_full;
	logic               dump_last;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign is_full   = (cnt_q == CW'(CAPACITY));
	assign dump_last = (idx_q == cnt_q - CW'(1));

	// match search: handles are unique, so an OR of the masked priorities is the hit
	always_comb begin
		found_c = 1'b0;
		mprio_c = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if ((CW'(i) < cnt_q) && (cell_h_q[i] == cmd_q.handle)) begin
				found_c = 1'b1;
				mprio_c = mprio_c | cell_p_q[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < CAPACITY; i++)
			before_v[i] = (CW'(i) < cnt_q) &&
				sorts_before(cell_p_q[i], cell_h_q[i], cmd_q.prio, cmd_q.handle);
	end

	// cell row: each cell picks its own value, its neighbor's, the new entry or cell 0
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cell_h_d[i] = cell_h_q[i];
			cell_p_d[i] = cell_p_q[i];
		end
		case (state_q)
			S_DROP: begin
				if (found_q) begin
					for (int i = 0; i < CAPACITY; i++) begin
						if ((CW'(i) < cnt_q) && !sorts_before(cell_p_q[i], cell_h_q[i],
								mprio_q, cmd_q.handle)) begin
							cell_h_d[i] = cell_h_q[(i + 1) % CAPACITY];
							cell_p_d[i] = cell_p_q[(i + 1) % CAPACITY];
						end
					end
				end
			end
			S_INSERT: begin
				if (!is_full) begin
					for (int i = 0; i < CAPACITY; i++) begin
						if (!before_v[i]) begin
							if (i == 0 || before_v[(i + CAPACITY - 1) % CAPACITY]) begin
								cell_h_d[i] = cmd_q.handle;
								cell_p_d[i] = cmd_q.prio;
							end else begin
								cell_h_d[i] = cell_h_q[(i + CAPACITY - 1) % CAPACITY];
								cell_p_d[i] = cell_p_q[(i + CAPACITY - 1) % CAPACITY];
							end
						end
					end
				end
			end
			S_DUMP: begin
				// rotate the occupied cells so the next entry sits in cell 0
				if (cnt_q != '0 && out_free) begin
					for (int i = 0; i < CAPACITY; i++) begin
						if (CW'(i + 1) == cnt_q) begin
							cell_h_d[i] = cell_h_q[0];
							cell_p_d[i] = cell_p_q[0];
						end else if (CW'(i) < cnt_q) begin
							cell_h_d[i] = cell_h_q[(i + 1) % CAPACITY];
							cell_p_d[i] = cell_p_q[(i + 1) % CAPACITY];
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		resp_d    = resp_q;
		emit      = 1'b0;
		emit_data = '{status: ST_DONE, out_handle: 32'd0, out_priority: 32'sd0, last: 1'b1};
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					case (q_cmd.kind)
						K_ADD, K_REMOVE: state_d = S_MATCH;
						K_DUMP:          state_d = S_DUMP;
						K_NULL: begin
							resp_d  = ST_NULL;
							state_d = S_RESP;
						end
						default: begin
							resp_d  = ST_DONE;
							state_d = S_RESP;
						end
					endcase
				end
			end
			S_MATCH: state_d = S_DROP;
			S_DROP: begin
				if (found_q) cnt_d = cnt_q - CW'(1);
				if (cmd_q.kind == K_ADD) begin
					state_d = S_INSERT;
				end else begin
					resp_d  = ST_DONE;
					state_d = S_RESP;
				end
			end
			S_INSERT: begin
				if (is_full) begin
					resp_d = ST_FULL;
				end else begin
					resp_d = ST_DONE;
					cnt_d  = cnt_q + CW'(1);
				end
				state_d = S_RESP;
			end
			S_RESP: begin
				emit_data.status = resp_q;
				if (out_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_DUMP: begin
				if (cnt_q == '0) begin
					emit_data.status = ST_EMPTY;
				end else begin
					emit_data.status       = ST_ENTRY;
					emit_data.out_handle   = cell_h_q[0];
					emit_data.out_priority = cell_p_q[0];
					emit_data.last         = dump_last;
				end
				if (out_free) begin
					emit = 1'b1;
					if (cnt_q == '0 || dump_last) begin
						idx_d   = '0;
						state_d = S_IDLE;
					end else begin
						idx_d = idx_q + CW'(1);
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			resp_q      <= ST_DONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			resp_q  <= resp_d;
			if (emit)           out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) cmd_q <= q_cmd;
		if (state_q == S_MATCH) begin
			found_q <= found_c;
			mprio_q <= mprio_c;
		end
		if (emit) out_data_q <= emit_data;
		for (int i = 0; i < CAPACITY; i++) begin
			cell_h_q[i] <= cell_h_d[i];
			cell_p_q[i] <= cell_p_d[i];
		end
	end

endmodule
`default_nettype wire

/* rtl/priority_ordered_handle_list.sv */
// From request accept to registered result, an add passes the back states idle,
// match, drop, insert and resp; a remove skips insert; a null add or null remove
// goes from idle to resp; a dump goes from idle to the dump state, which emits it.
// The back handles one request at a time and, while the output is taken, a dump
// emits one entry per cycle. A 2-deep queue takes requests while the back is busy.
// Reset clears the entry count and control; entry cells are not reset.
`default_nettype none
module priority_ordered_handle_list #(
	parameter int unsigned CAPACITY = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  plh_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  wire                out_ready,
	output plh_pkg::out_item_t out_data
);
	import plh_pkg::*;

	logic q_valid;
	logic q_pop;
	cmd_t q_cmd;

	plh_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop)
	);

	plh_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire
